/* rtl/dwfs_pkg.sv */
`timescale 1ns / 1ps

package dwfs_pkg;

   typedef logic [15:0] coord_type;
   typedef logic [15:0] color_type;
   typedef logic [7:0]  byte_type;
   typedef logic [31:0] count_type;
   typedef logic [1:0]  csr_index_type;

   // request operation codes
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_PULL  = 1'b1;

   // register indexes on the csr channel
   localparam csr_index_type CSR_ROW_SET   = 2'd0;
   localparam csr_index_type CSR_COL_SET   = 2'd1;
   localparam csr_index_type CSR_MEM_WRITE = 2'd2;

   localparam byte_type ROW_SET_RESET   = 8'd43;
   localparam byte_type COL_SET_RESET   = 8'd42;
   localparam byte_type MEM_WRITE_RESET = 8'd44;

   typedef enum logic [3:0] {
      STEP_ROW_CMD      = 4'd0,
      STEP_ROW_START_HI = 4'd1,
      STEP_ROW_START_LO = 4'd2,
      STEP_ROW_END_HI   = 4'd3,
      STEP_ROW_END_LO   = 4'd4,
      STEP_COL_CMD      = 4'd5,
      STEP_COL_START_HI = 4'd6,
      STEP_COL_START_LO = 4'd7,
      STEP_COL_END_HI   = 4'd8,
      STEP_COL_END_LO   = 4'd9,
      STEP_MEM_CMD      = 4'd10,
      STEP_PIXELS       = 4'd11
   } header_step_type;

   typedef struct packed {
      byte_type row_set;
      byte_type col_set;
      byte_type mem_write;
   } opcodes_type;

   typedef struct packed {
      logic      operation;
      coord_type x_start;
      coord_type x_end;
      coord_type y_start;
      coord_type y_end;
      logic      image_mode;
      color_type pixel_color;
   } req_payload_type;

   typedef struct packed {
      byte_type out_byte;
      logic     is_data;
      logic     last;
      logic     empty_res;
   } rsp_payload_type;

endpackage

/* rtl/dwfs_if.sv */
`timescale 1ns / 1ps

interface dwfs_req_if;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   dwfs_pkg::coord_type  x_start;
   dwfs_pkg::coord_type  x_end;
   dwfs_pkg::coord_type  y_start;
   dwfs_pkg::coord_type  y_end;
   logic                 image_mode;
   dwfs_pkg::color_type  pixel_color;

   modport source (output valid, operation, x_start, x_end, y_start, y_end, image_mode,
                   pixel_color, input ready);
   modport sink (input valid, operation, x_start, x_end, y_start, y_end, image_mode,
                 pixel_color, output ready);
endinterface

interface dwfs_rsp_if;
   logic               valid;
   logic               ready;
   dwfs_pkg::byte_type out_byte;
   logic               is_data;
   logic               last;
   logic               empty_res;

   modport source (output valid, out_byte, is_data, last, empty_res, input ready);
   modport sink (input valid, out_byte, is_data, last, empty_res, output ready);
endinterface

interface dwfs_csr_if;
   logic                    valid;
   logic                    ready;
   dwfs_pkg::csr_index_type index;
   dwfs_pkg::byte_type      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dwfs_csr.sv */
`timescale 1ns / 1ps

module dwfs_csr (
   input  logic                  clock,
   input  logic                  reset,
   dwfs_csr_if.sink              csr_ch,
   output dwfs_pkg::opcodes_type opcodes
);

   dwfs_pkg::opcodes_type opcodes_ff;
   dwfs_pkg::opcodes_type opcodes_in;

   assign csr_ch.ready = 1'b1;
   assign opcodes      = opcodes_ff;

   always_comb begin
      opcodes_in = opcodes_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            dwfs_pkg::CSR_ROW_SET:   opcodes_in.row_set   = csr_ch.data;
            dwfs_pkg::CSR_COL_SET:   opcodes_in.col_set   = csr_ch.data;
            dwfs_pkg::CSR_MEM_WRITE: opcodes_in.mem_write = csr_ch.data;
            default:                 opcodes_in = opcodes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opcodes_ff.row_set   <= dwfs_pkg::ROW_SET_RESET;
         opcodes_ff.col_set   <= dwfs_pkg::COL_SET_RESET;
         opcodes_ff.mem_write <= dwfs_pkg::MEM_WRITE_RESET;
      end else begin
         opcodes_ff <= opcodes_in;
      end
   end

endmodule

/* rtl/dwfs_seq.sv */
`timescale 1ns / 1ps

module dwfs_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_fire,
   input  dwfs_pkg::req_payload_type req,
   input  dwfs_pkg::opcodes_type     opcodes,
   output dwfs_pkg::rsp_payload_type result
);

   logic                      busy_ff, busy_in;
   dwfs_pkg::header_step_type step_ff, step_in;
   logic                      low_byte_next_ff, low_byte_next_in;
   dwfs_pkg::coord_type       x_start_ff, x_start_in;
   dwfs_pkg::coord_type       x_end_ff, x_end_in;
   dwfs_pkg::coord_type       y_start_ff, y_start_in;
   dwfs_pkg::coord_type       y_end_ff, y_end_in;
   dwfs_pkg::count_type       pixels_left_ff, pixels_left_in;
   dwfs_pkg::color_type       held_color_ff, held_color_in;
   logic                      held_mode_ff, held_mode_in;

   dwfs_pkg::coord_type x_span, y_span;
   dwfs_pkg::coord_type x_last, y_last;
   dwfs_pkg::color_type pix_color;
   logic                begin_fire, pull_fire, fin;

   assign begin_fire = req_fire && (req.operation == dwfs_pkg::OP_BEGIN);
   assign pull_fire  = req_fire && (req.operation == dwfs_pkg::OP_PULL);

   // inverted or empty windows give no pixels
   assign x_span = (req.x_end > req.x_start) ? req.x_end - req.x_start : '0;
   assign y_span = (req.y_end > req.y_start) ? req.y_end - req.y_start : '0;

   assign x_last = x_end_ff - dwfs_pkg::coord_type'(1);
   assign y_last = y_end_ff - dwfs_pkg::coord_type'(1);

   // image mode samples the color on the pull that sends the high byte
   assign pix_color = held_mode_ff ? req.pixel_color : held_color_ff;

   assign fin = busy_ff &&
                (((step_ff == dwfs_pkg::STEP_MEM_CMD) && (pixels_left_ff == '0)) ||
                 ((step_ff == dwfs_pkg::STEP_PIXELS) && low_byte_next_ff &&
                  (pixels_left_ff == dwfs_pkg::count_type'(1))));

   // next state
   always_comb begin
      busy_in          = busy_ff;
      step_in          = step_ff;
      low_byte_next_in = low_byte_next_ff;
      x_start_in       = x_start_ff;
      x_end_in         = x_end_ff;
      y_start_in       = y_start_ff;
      y_end_in         = y_end_ff;
      pixels_left_in   = pixels_left_ff;
      held_color_in    = held_color_ff;
      held_mode_in     = held_mode_ff;
      priority if (begin_fire) begin
         busy_in          = 1'b1;
         step_in          = dwfs_pkg::STEP_ROW_CMD;
         low_byte_next_in = 1'b0;
         x_start_in       = req.x_start;
         x_end_in         = req.x_end;
         y_start_in       = req.y_start;
         y_end_in         = req.y_end;
         pixels_left_in   = dwfs_pkg::count_type'(x_span) * dwfs_pkg::count_type'(y_span);
         held_color_in    = req.pixel_color;
         held_mode_in     = req.image_mode;
      end else if (pull_fire && busy_ff) begin
         if (fin) begin
            busy_in          = 1'b0;
            step_in          = dwfs_pkg::STEP_ROW_CMD;
            low_byte_next_in = 1'b0;
         end else if (step_ff == dwfs_pkg::STEP_PIXELS) begin
            low_byte_next_in = !low_byte_next_ff;
            if (low_byte_next_ff) begin
               pixels_left_in = pixels_left_ff - dwfs_pkg::count_type'(1);
            end else begin
               held_color_in = pix_color;
            end
         end else begin
            step_in = dwfs_pkg::header_step_type'(step_ff + 4'd1);
         end
      end else begin
         busy_in = busy_ff;
      end
   end

   // result for a pull in this cycle
   always_comb begin
      result.out_byte  = '0;
      result.is_data   = 1'b1;
      result.last      = fin;
      result.empty_res = 1'b0;
      unique case (step_ff)
         dwfs_pkg::STEP_ROW_CMD: begin
            result.out_byte = opcodes.row_set;
            result.is_data  = 1'b0;
         end
         dwfs_pkg::STEP_ROW_START_HI: result.out_byte = y_start_ff[15:8];
         dwfs_pkg::STEP_ROW_START_LO: result.out_byte = y_start_ff[7:0];
         dwfs_pkg::STEP_ROW_END_HI:   result.out_byte = y_last[15:8];
         dwfs_pkg::STEP_ROW_END_LO:   result.out_byte = y_last[7:0];
         dwfs_pkg::STEP_COL_CMD: begin
            result.out_byte = opcodes.col_set;
            result.is_data  = 1'b0;
         end
         dwfs_pkg::STEP_COL_START_HI: result.out_byte = x_start_ff[15:8];
         dwfs_pkg::STEP_COL_START_LO: result.out_byte = x_start_ff[7:0];
         dwfs_pkg::STEP_COL_END_HI:   result.out_byte = x_last[15:8];
         dwfs_pkg::STEP_COL_END_LO:   result.out_byte = x_last[7:0];
         dwfs_pkg::STEP_MEM_CMD: begin
            result.out_byte = opcodes.mem_write;
            result.is_data  = 1'b0;
         end
         dwfs_pkg::STEP_PIXELS:
            result.out_byte = low_byte_next_ff ? held_color_ff[7:0] : pix_color[15:8];
         default: result.out_byte = '0;
      endcase
      if (!busy_ff) begin
         result.out_byte  = '0;
         result.is_data   = 1'b0;
         result.last      = 1'b0;
         result.empty_res = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         step_ff          <= dwfs_pkg::STEP_ROW_CMD;
         low_byte_next_ff <= 1'b0;
      end else begin
         busy_ff          <= busy_in;
         step_ff          <= step_in;
         low_byte_next_ff <= low_byte_next_in;
      end
   end

   always_ff @(posedge clock) begin
      x_start_ff     <= x_start_in;
      x_end_ff       <= x_end_in;
      y_start_ff     <= y_start_in;
      y_end_ff       <= y_end_in;
      pixels_left_ff <= pixels_left_in;
      held_color_ff  <= held_color_in;
      held_mode_ff   <= held_mode_in;
   end

endmodule

/* rtl/dwfs_out.sv */
`timescale 1ns / 1ps

module dwfs_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  dwfs_pkg::rsp_payload_type result,
   output logic                      slot_free,
   dwfs_rsp_if.source                rsp_ch
);

   logic                      valid_ff, valid_in;
   dwfs_pkg::rsp_payload_type data_ff, data_in;

   // the register can take a new byte in the same cycle the old one leaves
   assign slot_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.out_byte  = data_ff.out_byte;
   assign rsp_ch.is_data   = data_ff.is_data;
   assign rsp_ch.last      = data_ff.last;
   assign rsp_ch.empty_res = data_ff.empty_res;

endmodule

/* rtl/display_window_fill_sequencer_core.sv */
`timescale 1ns / 1ps

// Panel window fill sequencer.
// req_ch: a begin transfer (operation 0) latches a window, fill mode and
//   color and returns nothing; a pull transfer (operation 1) returns one
//   byte of the panel stream on rsp_ch with its command/data flag.
// Stream per window: row-set command, 4 row bytes, column-set command,
//   4 column bytes, memory-write command, then 2 bytes per pixel, high
//   byte first. last marks the final byte; a pull while idle returns
//   empty_res with all other fields zero.
// csr_ch: writes the three command opcodes, always ready, one per cycle.
// Latency: the byte for a pull is on rsp_ch the cycle after its transfer.
// Throughput: one item per cycle while the output slot is free; all work is one pass of logic between
//   the window state registers and the output register.
// Stall: req_ch.ready drops only while the output register is full and
//   rsp_ch.ready is low; a byte leaving frees the slot in the same cycle.
// Reset: synchronous; the sequencer goes idle, the output register empties
//   and the opcodes return to 43, 42 and 44.

module display_window_fill_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   dwfs_req_if.sink    req_ch,
   dwfs_rsp_if.source  rsp_ch,
   dwfs_csr_if.sink    csr_ch
);

   dwfs_pkg::opcodes_type     opcodes;
   dwfs_pkg::req_payload_type req;
   dwfs_pkg::rsp_payload_type result;
   logic                      slot_free;
   logic                      req_fire;

   assign req_ch.ready = slot_free;
   assign req_fire     = req_ch.valid && slot_free;

   assign req.operation   = req_ch.operation;
   assign req.x_start     = req_ch.x_start;
   assign req.x_end       = req_ch.x_end;
   assign req.y_start     = req_ch.y_start;
   assign req.y_end       = req_ch.y_end;
   assign req.image_mode  = req_ch.image_mode;
   assign req.pixel_color = req_ch.pixel_color;

   dwfs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_ch  (csr_ch),
      .opcodes (opcodes)
   );

   dwfs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req      (req),
      .opcodes  (opcodes),
      .result   (result)
   );

   dwfs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire && (req_ch.operation == dwfs_pkg::OP_PULL)),
      .result    (result),
      .slot_free (slot_free),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* rtl/dwfs_checker.sv */
`timescale 1ns / 1ps

module dwfs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_operation,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input dwfs_pkg::byte_type rsp_out_byte,
   input logic               rsp_is_data,
   input logic               rsp_last,
   input logic               rsp_empty_res
);

   logic req_xfer, rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_is_data) && $stable(rsp_last) && $stable(rsp_empty_res))
      else $error("rsp changed while stalled");

   // every pull gives a byte in the next cycle
   a_pull_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_operation == dwfs_pkg::OP_PULL) |=> rsp_valid)
      else $error("pull without a response");

   // a begin produces no byte of its own
   a_begin_silent: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_operation == dwfs_pkg::OP_BEGIN) && (!rsp_valid || rsp_xfer)
      |=> !rsp_valid)
      else $error("begin produced a response");

   // empty response carries nothing else
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_res |-> (rsp_out_byte == '0) && !rsp_is_data && !rsp_last)
      else $error("empty response with payload");

   // the first byte after a begin is the row-set command
   a_first_cmd: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_operation == dwfs_pkg::OP_BEGIN) ##1
      req_xfer && (req_operation == dwfs_pkg::OP_PULL)
      |=> rsp_valid && !rsp_is_data && !rsp_empty_res && !rsp_last)
      else $error("window did not open with a command byte");

endmodule

bind display_window_fill_sequencer_core dwfs_checker u_dwfs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_operation (req_ch.operation),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_out_byte  (rsp_ch.out_byte),
   .rsp_is_data   (rsp_ch.is_data),
   .rsp_last      (rsp_ch.last),
   .rsp_empty_res (rsp_ch.empty_res)
);
